@@ src/joint_pose_ramp_sequencer_core_assert.svh @@
// Assertion macros for the pose ramp sequencer checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef JOINT_POSE_RAMP_SEQUENCER_CORE_ASSERT_SVH
`define JOINT_POSE_RAMP_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define JPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/jprs_pkg.sv @@
// Shared types, codes and constants of the pose ramp sequencer.
// No dependencies; used by the core and its checker.
package jprs_pkg;

  localparam int NUM_JOINTS_DEF  = 12;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int JOINT_W   = 4;
  localparam int TICK_W    = 16;

  localparam logic [TICK_W-1:0] CAPTURE_TICKS = 16'd10;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
  localparam logic signed [15:0] FF_TORQUE    = -16'sd2662;

  localparam logic [CFG_W-1:0] STIFFNESS_RST = 16'd3840;
  localparam logic [CFG_W-1:0] DAMPING_RST   = 16'd192;
  localparam logic [CFG_W-1:0] HOLD_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] RISE_RST      = 16'd800;
  localparam logic [CFG_W-1:0] LOWER_RST     = 16'd800;
  localparam logic signed [CFG_W-1:0] STAND_HIP_RST   = 16'sd0;
  localparam logic signed [CFG_W-1:0] STAND_THIGH_RST = 16'sd2744;
  localparam logic signed [CFG_W-1:0] STAND_CALF_RST  = -16'sd5325;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFFNESS   = 3'd0,
    REG_DAMPING     = 3'd1,
    REG_HOLD        = 3'd2,
    REG_RISE        = 3'd3,
    REG_LOWER       = 3'd4,
    REG_STAND_HIP   = 3'd5,
    REG_STAND_THIGH = 3'd6,
    REG_STAND_CALF  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_CAPTURE = 3'd0,
    PH_HOLD    = 3'd1,
    PH_RISE    = 3'd2,
    PH_STAND   = 3'd3,
    PH_LOWER   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    MODE_CAP    = 3'd0,
    MODE_CAPEND = 3'd1,
    MODE_HOLD   = 3'd2,
    MODE_RISE   = 3'd3,
    MODE_STAND  = 3'd4,
    MODE_LOWER  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_HIP   = 2'd0,
    KIND_THIGH = 2'd1,
    KIND_CALF  = 2'd2
  } joint_kind_t;

  function automatic joint_kind_t joint_kind(input logic [JOINT_W-1:0] j);
    joint_kind_t k;
    case (j) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: k = KIND_HIP;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       k = KIND_THIGH;
      default:                              k = KIND_CALF;
    endcase
    return k;
  endfunction

endpackage

@@ src/jprs_div.sv @@
// Shift-subtract divider: one quotient bit per cycle.
// Quotient must fit QW bits (dividend < divisor * 2**QW). No package use.
module jprs_div #(
  parameter int QW = 16,
  parameter int DW = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QW+DW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [QW-1:0]    quotient,
  output logic             done
);

  localparam int PW = QW + DW;
  localparam int CW = $clog2(QW + 1);

  logic [PW-1:0] rem_r;
  logic [PW-1:0] dsh_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic          fits;

  assign fits = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= PW'(divisor) << (QW - 1);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[QW-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ src/joint_pose_ramp_sequencer_core.sv @@
// Pose ramp sequencer core: phase sequencer, start pose store and ramp datapath.
// Depends on jprs_pkg and jprs_div.
//
// Usage: one measured joint angle per input transaction on in_* (valid/stall);
// joint 0 opens a control tick and carries the quit request. Each input
// transaction yields exactly one command transaction on out_*. Registers are
// written on cfg_* (write enable, index, data); the user must write them only
// while the block is idle, as the block does not enforce this.
// Steps: a ramp item (rise or lower phase, inside its duration) passes the
// tick, read, multiply, divider start and divide states (the shift-subtract
// divider yields one quotient bit per cycle), then the finish state and the
// output register; other items skip the two divider states.
// One item is in flight at a time; in_stall is high from accept until the
// result is in the output register, so the next item is taken while a result
// still waits there.
// Reset (synchronous, rst_n low): capture phase, tick count 0, registers at
// their defaults, output empty. The start pose store has no reset.
// Receiver stall: out_* holds its transaction; the block finishes the next item
// and waits with it until the output register frees up.
module joint_pose_ramp_sequencer_core #(
  parameter int NUM_JOINTS  = jprs_pkg::NUM_JOINTS_DEF,
  parameter int ANGLE_WIDTH = jprs_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [jprs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jprs_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [jprs_pkg::JOINT_W-1:0]          in_joint_index,
  input  logic signed [ANGLE_WIDTH-1:0]         in_measured_angle,
  input  logic                                  in_quit_request,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ANGLE_WIDTH-1:0]         out_target_angle,
  output logic [jprs_pkg::CFG_W-1:0]            out_stiffness_out,
  output logic [jprs_pkg::CFG_W-1:0]            out_damping_out,
  output logic signed [15:0]                    out_feedforward_torque,
  output logic                                  out_command_sent,
  output logic [2:0]                            out_phase
);

  import jprs_pkg::*;

  localparam int AW = ANGLE_WIDTH;
  localparam int EW = (AW > CFG_W) ? AW : CFG_W;
  localparam int VW = EW + 1;
  localparam int PW = EW + TICK_W;
  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int XW = (JW > JOINT_W) ? JW : JOINT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TICK  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_DIVGO = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0]        stiffness_r, damping_r, hold_r, rise_r, lower_r;
  logic signed [CFG_W-1:0] stand_hip_r, stand_thigh_r, stand_calf_r;

  // sequencing state
  phase_t            phase_r, phase_nxt;
  mode_t             mode_r, mode_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  // latched input transaction
  logic [JOINT_W-1:0]   joint_r;
  logic signed [AW-1:0] angle_r;
  logic                 quit_r;

  // pose store
  logic [AW-1:0] pose_mem [NUM_JOINTS];
  logic [AW-1:0] pose_rd_r;
  logic [XW-1:0] joint_x;
  logic [JW-1:0] pose_addr;
  logic          joint_ok;

  // ramp datapath
  logic signed [EW-1:0] start_x, stand_x, from_x, to_x, direct_x;
  logic signed [VW-1:0] diff;
  logic [EW-1:0]        diff_mag;
  logic [TICK_W-1:0]    dur;
  logic                 is_ramp, ramp_phase;
  logic [PW-1:0]        prod_r;
  logic signed [EW-1:0] from_r, tgt_r;
  logic                 neg_r, ramp_r;
  logic                 div_start, div_done;
  logic [EW-1:0]        div_quo;
  logic signed [VW:0]   from_ext, quo_ext, ramp_sum;
  logic [TICK_W-1:0]    tick_inc;

  // output register
  logic                 out_valid_r;
  logic signed [AW-1:0] out_target_r;
  logic [CFG_W-1:0]     out_stiff_r, out_damp_r;
  logic signed [15:0]   out_ff_r;
  logic                 out_sent_r;
  phase_t               out_phase_r;
  logic                 out_load;
  logic                 gains_on, sent_on;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r   <= STIFFNESS_RST;
      damping_r     <= DAMPING_RST;
      hold_r        <= HOLD_RST;
      rise_r        <= RISE_RST;
      lower_r       <= LOWER_RST;
      stand_hip_r   <= STAND_HIP_RST;
      stand_thigh_r <= STAND_THIGH_RST;
      stand_calf_r  <= STAND_CALF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STIFFNESS:   stiffness_r   <= cfg_wdata;
        REG_DAMPING:     damping_r     <= cfg_wdata;
        REG_HOLD:        hold_r        <= cfg_wdata;
        REG_RISE:        rise_r        <= cfg_wdata;
        REG_LOWER:       lower_r       <= cfg_wdata;
        REG_STAND_HIP:   stand_hip_r   <= cfg_wdata;
        REG_STAND_THIGH: stand_thigh_r <= cfg_wdata;
        REG_STAND_CALF:  stand_calf_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- tick / phase update ----------------
  assign tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;

  always_comb begin
    phase_t ph;
    logic [TICK_W-1:0] t;
    ph        = phase_r;
    t         = tick_inc;
    mode_nxt  = mode_r;
    if (quit_r && (phase_r == PH_STAND)) begin
      ph = PH_LOWER;
      t  = '0;
    end
    case (ph)
      PH_HOLD: begin
        mode_nxt = MODE_HOLD;
        if (t >= hold_r) begin
          ph = PH_RISE;
          t  = '0;
        end
      end
      PH_RISE: begin
        if (t <= rise_r) begin
          mode_nxt = MODE_RISE;
        end else begin
          ph       = PH_STAND;
          mode_nxt = MODE_STAND;
        end
      end
      PH_STAND: mode_nxt = MODE_STAND;
      PH_LOWER: mode_nxt = MODE_LOWER;
      default: begin
        if (t <= CAPTURE_TICKS) begin
          ph       = PH_CAPTURE;
          mode_nxt = MODE_CAP;
        end else begin
          ph       = PH_HOLD;
          t        = '0;
          mode_nxt = MODE_CAPEND;
        end
      end
    endcase
    phase_nxt = ph;
    tick_nxt  = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CAPTURE;
      mode_r  <= MODE_CAP;
      tick_r  <= '0;
    end else if ((state_r == S_TICK) && (joint_r == '0)) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // ---------------- input latch ----------------
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      joint_r <= in_joint_index;
      angle_r <= in_measured_angle;
      quit_r  <= in_quit_request;
    end
  end

  // ---------------- pose store ----------------
  assign joint_x   = XW'(joint_r);
  assign pose_addr = joint_x[JW-1:0];
  assign joint_ok  = (32'(joint_r) < NUM_JOINTS);

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      if ((mode_r == MODE_CAP) && joint_ok) begin
        pose_mem[pose_addr] <= angle_r;
      end
      pose_rd_r <= pose_mem[pose_addr];
    end
  end

  // ---------------- ramp setup ----------------
  always_comb begin
    start_x = joint_ok ? EW'(signed'(pose_rd_r)) : '0;
    case (joint_kind(joint_r))
      KIND_HIP:   stand_x = EW'(stand_hip_r);
      KIND_THIGH: stand_x = EW'(stand_thigh_r);
      default:    stand_x = EW'(stand_calf_r);
    endcase
    ramp_phase = (mode_r == MODE_RISE) || (mode_r == MODE_LOWER);
    if (mode_r == MODE_LOWER) begin
      from_x = stand_x;
      to_x   = start_x;
      dur    = lower_r;
    end else begin
      from_x = start_x;
      to_x   = stand_x;
      dur    = rise_r;
    end
    is_ramp  = ramp_phase && (dur != '0) && (tick_r < dur);
    diff     = VW'(to_x) - VW'(from_x);
    diff_mag = diff[VW-1] ? EW'(-diff) : EW'(diff);
    case (mode_r)
      MODE_HOLD:  direct_x = start_x;
      MODE_STAND: direct_x = stand_x;
      MODE_RISE, MODE_LOWER: direct_x = to_x;
      default:    direct_x = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= PW'(diff_mag) * PW'(tick_r);
      neg_r  <= diff[VW-1];
      from_r <= from_x;
      tgt_r  <= direct_x;
      ramp_r <= is_ramp;
    end
  end

  assign div_start = (state_r == S_DIVGO);

  jprs_div #(
    .QW(EW),
    .DW(TICK_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (dur),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign from_ext = (VW+1)'(from_r);
  assign quo_ext  = signed'({2'b00, div_quo});
  assign ramp_sum = neg_r ? (from_ext - quo_ext) : (from_ext + quo_ext);

  // ---------------- sequencer ----------------
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_TICK;
      S_TICK:  state_nxt = S_READ;
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = is_ramp ? S_DIVGO : S_FIN;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // ---------------- output register ----------------
  assign gains_on = (mode_r == MODE_HOLD) || (mode_r == MODE_RISE) ||
                    (mode_r == MODE_STAND) || (mode_r == MODE_LOWER);
  assign sent_on  = (mode_r == MODE_RISE) || (mode_r == MODE_STAND) ||
                    (mode_r == MODE_LOWER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_target_r <= ramp_r ? ramp_sum[AW-1:0] : tgt_r[AW-1:0];
      out_stiff_r  <= gains_on ? stiffness_r : '0;
      out_damp_r   <= gains_on ? damping_r : '0;
      out_ff_r     <= (sent_on && ((joint_r == 4'd0) || (joint_r == 4'd3))) ?
                      FF_TORQUE : '0;
      out_sent_r   <= sent_on;
      case (mode_r)
        MODE_HOLD:  out_phase_r <= PH_HOLD;
        MODE_RISE:  out_phase_r <= PH_RISE;
        MODE_STAND: out_phase_r <= PH_STAND;
        MODE_LOWER: out_phase_r <= PH_LOWER;
        default:    out_phase_r <= PH_CAPTURE;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_target_angle       = out_target_r;
  assign out_stiffness_out      = out_stiff_r;
  assign out_damping_out        = out_damp_r;
  assign out_feedforward_torque = out_ff_r;
  assign out_command_sent       = out_sent_r;
  assign out_phase              = out_phase_r;

endmodule

@@ src/jprs_checker.sv @@
// Port-level checker for the pose ramp sequencer core, bound into every core instance.
// Depends on jprs_pkg and joint_pose_ramp_sequencer_core_assert.svh.
`include "joint_pose_ramp_sequencer_core_assert.svh"

module jprs_checker #(
  parameter int ANGLE_WIDTH = jprs_pkg::ANGLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [ANGLE_WIDTH-1:0]  out_target_angle,
  input logic [jprs_pkg::CFG_W-1:0]     out_stiffness_out,
  input logic [jprs_pkg::CFG_W-1:0]     out_damping_out,
  input logic signed [15:0]             out_feedforward_torque,
  input logic                           out_command_sent,
  input logic [2:0]                     out_phase
);

  import jprs_pkg::*;

  `JPRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_target_angle) && $stable(out_phase), "stalled output transaction changed")

  `JPRS_ASSERT_NOW(a_sent_phase, out_valid, out_command_sent == ((out_phase == PH_RISE) || (out_phase == PH_STAND) || (out_phase == PH_LOWER)), "command_sent does not match phase")

  `JPRS_ASSERT_NOW(a_capture_quiet, out_valid && (out_phase == PH_CAPTURE), (out_stiffness_out == '0) && (out_damping_out == '0) && (out_target_angle == '0) && (out_feedforward_torque == '0), "capture command not zero")

  `JPRS_ASSERT_NOW(a_ff_value, out_valid && (out_feedforward_torque != '0), out_command_sent && (out_feedforward_torque == FF_TORQUE), "unexpected feedforward torque")

  `JPRS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again right after a transaction")

endmodule

bind joint_pose_ramp_sequencer_core jprs_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_jprs_checker (.*);

@@ dv/joint_pose_ramp_sequencer_core_tb.sv @@
// Testbench for joint_pose_ramp_sequencer_core: random and directed joint samples
// through capture, hold, rise, stand and lower, checked against an in-bench predictor.
// Depends on jprs_pkg and the core RTL.
`timescale 1ns / 100ps

module joint_pose_ramp_sequencer_core_tb;
  import jprs_pkg::*;

  localparam int NJ          = 12;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [15:0] target;
    logic [15:0]        stiffness;
    logic [15:0]        damping;
    logic signed [15:0] torque;
    logic               sent;
    logic [2:0]         phase;
  } command_t;

  class pose_command_scoreboard;
    logic [15:0]        regs [8];
    phase_t             phase_q;
    mode_t              mode_q;
    logic [15:0]        ticks;
    logic signed [15:0] start_pose [NJ];
    command_t           pending_cmds [$];
    int                 mismatches;

    function new();
      regs[REG_STIFFNESS]   = STIFFNESS_RST;
      regs[REG_DAMPING]     = DAMPING_RST;
      regs[REG_HOLD]        = HOLD_RST;
      regs[REG_RISE]        = RISE_RST;
      regs[REG_LOWER]       = LOWER_RST;
      regs[REG_STAND_HIP]   = STAND_HIP_RST;
      regs[REG_STAND_THIGH] = STAND_THIGH_RST;
      regs[REG_STAND_CALF]  = STAND_CALF_RST;
      phase_q = PH_CAPTURE;
      mode_q = MODE_CAP;
      ticks = '0;
      foreach (start_pose[i]) start_pose[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [15:0] v);
      regs[r] = v;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    function logic signed [15:0] ramp_angle(longint from, longint to, longint t, longint dur);
      if (dur == 0 || t >= dur) return 16'(to);
      return 16'(from + ((to - from) * t) / dur);
    endfunction

    function void open_tick(logic quit);
      logic [15:0] t;
      t = (ticks != TICK_MAX) ? ticks + 16'd1 : TICK_MAX;
      if (quit && phase_q == PH_STAND) begin
        phase_q = PH_LOWER;
        t = '0;
      end
      case (phase_q)
        PH_HOLD: begin
          mode_q = MODE_HOLD;
          if (t >= regs[REG_HOLD]) begin
            phase_q = PH_RISE;
            t = '0;
          end
        end
        PH_RISE: begin
          if (t <= regs[REG_RISE]) begin
            mode_q = MODE_RISE;
          end else begin
            phase_q = PH_STAND;
            mode_q = MODE_STAND;
          end
        end
        PH_STAND: mode_q = MODE_STAND;
        PH_LOWER: mode_q = MODE_LOWER;
        default: begin
          if (t <= CAPTURE_TICKS) begin
            phase_q = PH_CAPTURE;
            mode_q = MODE_CAP;
          end else begin
            phase_q = PH_HOLD;
            t = '0;
            mode_q = MODE_CAPEND;
          end
        end
      endcase
      ticks = t;
    endfunction

    function void note_sample(logic [3:0] j, logic signed [15:0] ang, logic quit);
      command_t           c;
      bit                 in_range;
      logic signed [15:0] sp;
      logic signed [15:0] st;
      if (j == 4'd0) open_tick(quit);
      in_range = (j < NJ);
      if (mode_q == MODE_CAP && in_range) start_pose[j] = ang;
      sp = in_range ? start_pose[j] : 16'sd0;
      st = regs[int'(REG_STAND_HIP) + int'(j % 3)];
      c = '0;
      c.phase = PH_CAPTURE;
      if (mode_q >= MODE_HOLD) begin
        c.stiffness = regs[REG_STIFFNESS];
        c.damping = regs[REG_DAMPING];
      end
      if (mode_q >= MODE_RISE) begin
        c.sent = 1'b1;
        if (j == 4'd0 || j == 4'd3) c.torque = FF_TORQUE;
      end
      case (mode_q)
        MODE_HOLD: begin
          c.target = sp;
          c.phase = PH_HOLD;
        end
        MODE_RISE: begin
          c.target = ramp_angle(longint'(sp), longint'(st), longint'(ticks),
                                longint'(regs[REG_RISE]));
          c.phase = PH_RISE;
        end
        MODE_STAND: begin
          c.target = st;
          c.phase = PH_STAND;
        end
        MODE_LOWER: begin
          c.target = ramp_angle(longint'(st), longint'(sp), longint'(ticks),
                                longint'(regs[REG_LOWER]));
          c.phase = PH_LOWER;
        end
        default: ;
      endcase
      pending_cmds.push_back(c);
    endfunction

    function string show(command_t c);
      return $sformatf("angle=%0d kp=%0d kd=%0d tau=%0d sent=%0d phase=%0d",
                       $signed(c.target), c.stiffness, c.damping, $signed(c.torque),
                       c.sent, c.phase);
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command transaction: %s", show(got));
        return;
      end
      want = pending_cmds.pop_front();
      if (got.target !== want.target || got.stiffness !== want.stiffness ||
          got.damping !== want.damping || got.torque !== want.torque ||
          got.sent !== want.sent || got.phase !== want.phase) begin
        mismatches++;
        if (mismatches <= 10)
          $display("command mismatch: expected %s, actual %s", show(want), show(got));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [JOINT_W-1:0] in_joint_index = '0;
  logic signed [15:0] in_measured_angle = '0;
  logic in_quit_request = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_target_angle;
  logic [CFG_W-1:0] out_stiffness_out;
  logic [CFG_W-1:0] out_damping_out;
  logic signed [15:0] out_feedforward_torque;
  logic out_command_sent;
  logic [2:0] out_phase;

  pose_command_scoreboard sb = new();
  int samples_sent = 0;
  int in_idle_pct = 21;
  int out_idle_pct = 61;
  int cycle_count = 0;
  cfg_reg_t staged_regs [$];
  logic [15:0] staged_vals [$];

  joint_pose_ramp_sequencer_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_joint_index(in_joint_index),
    .in_measured_angle(in_measured_angle),
    .in_quit_request(in_quit_request),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_target_angle(out_target_angle),
    .out_stiffness_out(out_stiffness_out),
    .out_damping_out(out_damping_out),
    .out_feedforward_torque(out_feedforward_torque),
    .out_command_sent(out_command_sent),
    .out_phase(out_phase)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_command(command_t'{out_target_angle, out_stiffness_out, out_damping_out,
                                  out_feedforward_torque, out_command_sent, out_phase});
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; returns at the accepting edge
  task automatic send_sample(input logic [3:0] j, input logic signed [15:0] ang,
                             input logic quit);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_index <= j;
    in_measured_angle <= ang;
    in_quit_request <= quit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(j, ang, quit);
    samples_sent++;
    if (samples_sent < 350) begin
      in_idle_pct = 21;
      out_idle_pct = 61;
    end else if (samples_sent < 700) begin
      in_idle_pct = 61;
      out_idle_pct = 21;
    end else begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
  endtask

  task automatic full_tick(input logic quit0);
    for (int j = 0; j < NJ; j++)
      send_sample(4'(j), rand_angle(), (j == 0) ? quit0 : logic'($urandom_range(1)));
  endtask

  task automatic noisy_tick(input logic quit0);
    int n;
    logic [3:0] j;
    send_sample(4'd0, rand_angle(), quit0);
    n = $urandom_range(8);
    repeat (n) begin
      j = 4'(($urandom_range(99) < 8) ? $urandom_range(15, 12) : $urandom_range(11, 1));
      send_sample(j, rand_angle(), 1'($urandom_range(1)));
    end
  endtask

  // quits stay off while standing so the lie-down point is chosen explicitly
  task automatic run_ticks(input int n);
    logic q;
    repeat (n) begin
      q = (sb.phase_q != PH_STAND) && ($urandom_range(2) == 0);
      if ($urandom_range(99) < 75) full_tick(q);
      else noisy_tick(q);
    end
  endtask

  function automatic void stage_write(cfg_reg_t r, logic [15:0] v);
    staged_regs.push_back(r);
    staged_vals.push_back(v);
  endfunction

  task automatic commit_config();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    while (staged_regs.size() != 0) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= staged_regs[0];
      cfg_wdata <= staged_vals[0];
      sb.write_reg(staged_regs.pop_front(), staged_vals.pop_front());
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // samples ahead of the first tick, out-of-range joints included
    send_sample(4'd5, 16'sh8000, 1'b1);
    send_sample(4'd11, 16'sh7FFF, 1'b0);
    send_sample(4'd12, 16'sd1234, 1'b1);
    send_sample(4'd15, -16'sd1, 1'b0);
    send_sample(4'd9, 16'sd0, 1'b1);

    // capture: every joint stored on each tick
    repeat (10) full_tick(1'($urandom_range(1)));

    stage_write(REG_HOLD, 16'd8);
    commit_config();
    full_tick(1'b0);
    run_ticks(4);

    stage_write(REG_HOLD, 16'hFFFF);
    stage_write(REG_STIFFNESS, 16'd0);
    stage_write(REG_DAMPING, 16'hFFFF);
    commit_config();
    run_ticks(3);

    stage_write(REG_HOLD, 16'd1);
    stage_write(REG_RISE, 16'd30);
    stage_write(REG_STAND_HIP, 16'h8000);
    stage_write(REG_STAND_THIGH, 16'h7FFF);
    stage_write(REG_STAND_CALF, rand_angle());
    commit_config();
    run_ticks(13);

    stage_write(REG_RISE, 16'hFFFF);
    stage_write(REG_STIFFNESS, 16'hFFFF);
    stage_write(REG_DAMPING, 16'd0);
    stage_write(REG_STAND_CALF, rand_angle());
    commit_config();
    run_ticks(6);

    stage_write(REG_RISE, 16'd1);
    stage_write(REG_STAND_HIP, 16'h7FFF);
    stage_write(REG_STAND_THIGH, 16'h8000);
    commit_config();
    run_ticks(5);

    stage_write(REG_STIFFNESS, 16'($urandom));
    stage_write(REG_DAMPING, 16'($urandom));
    stage_write(REG_LOWER, 16'd25);
    commit_config();
    run_ticks(3);
    full_tick(1'b1);
    run_ticks(10);

    stage_write(REG_STAND_HIP, rand_angle());
    stage_write(REG_STAND_THIGH, rand_angle());
    stage_write(REG_STAND_CALF, rand_angle());
    stage_write(REG_LOWER, 16'hFFFF);
    commit_config();
    run_ticks(5);

    stage_write(REG_LOWER, 16'd1);
    commit_config();
    run_ticks(3);

    // zero-length lowering ramp
    stage_write(REG_LOWER, 16'd0);
    commit_config();
    run_ticks(2);

    while (samples_sent < 1060) begin
      if ($urandom_range(1)) stage_write(REG_LOWER, 16'($urandom_range(80)));
      if ($urandom_range(1))
        stage_write(cfg_reg_t'(int'(REG_STAND_HIP) + $urandom_range(2)), rand_angle());
      if ($urandom_range(3) == 0) stage_write(REG_STIFFNESS, 16'($urandom));
      if ($urandom_range(3) == 0) stage_write(REG_DAMPING, 16'($urandom));
      commit_config();
      run_ticks($urandom_range(6, 2));
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
